[src/sorted_min_priority_queue_defines.svh]
// assertion macros for the sorted min priority queue checker
// no dependencies; included by files that hold assertions
`ifndef SORTED_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_MIN_PRIORITY_QUEUE_DEFINES_SVH

// clocked assertion, off while reset is active
`define SPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds across reset release
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/spq_pkg.sv]
// types and codes shared by the sorted min priority queue modules
// no dependencies
package spq_pkg;

	localparam int KEY_W = 32;
	localparam int OCC_W = 5;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [OCC_W-1:0] occ_t;

	typedef enum logic {
		ACT_INSERT  = 1'b0,
		ACT_EXTRACT = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		action_t action;
		key_t    key;
	} req_t;

	typedef struct packed {
		key_t    result_key;
		status_t status;
		occ_t    occupancy;
	} rsp_t;

	// what one cell shows its neighbors
	typedef struct packed {
		logic lt;
		key_t key;
	} link_t;

endpackage

[src/spq_cell.sv]
// one slot of the sorted register chain
// depends on spq_pkg
module spq_cell import spq_pkg::*; (
	input  logic  clk,
	input  logic  ins_en,
	input  logic  ext_en,
	input  key_t  new_key,
	input  logic  occ,
	input  link_t left,
	input  key_t  right_key,
	output link_t link
);

	key_t key_q;

	assign link.key = key_q;
	assign link.lt  = occ && (key_q < new_key);

	// ext takes right key; insert keeps smaller key, else new/left key
	always_ff @(posedge clk) begin
		if (ext_en) begin
			key_q <= right_key;
		end else if (ins_en && !link.lt) begin
			key_q <= left.lt ? new_key : left.key;
		end
	end

endmodule

[src/sorted_min_priority_queue.sv]
// Sorted min priority queue: a row of key cells kept in ascending order.
// Input channel req (req_valid/req_ready) carries an action and a signed
// key; output channel rsp (rsp_valid/rsp_ready) carries result_key, status
// and occupancy, one result item per input item, in order.
// An insert places its key in sorted position: every cell compares its own
// key with the new one in the same cycle and keeps, takes the new key or
// takes its left neighbor's key. An extract returns the head cell and every
// cell takes its right neighbor's key.
// rsp_valid rises in the cycle after acceptance; one item is taken
// every cycle as long as the output register is free or being drained,
// since the chain of cells finishes each item in its accepting cycle.
// An extract from an empty queue returns -1 with the empty status; an
// insert into a queue holding DEPTH keys is dropped with the full status.
// Reset empties the queue and the output register; the cell keys are not
// cleared, only the fill count is. When rsp_ready is low with a result
// waiting, req_ready drops and the queue holds its state.
// depends on spq_pkg and spq_cell
module sorted_min_priority_queue import spq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] cnt_q, cnt_d;
	logic          accept, is_ext, empty, full, ins_en, ext_en;
	logic          rsp_valid_q;
	rsp_t          rsp_q, rsp_d;
	link_t         lnk [DEPTH];
	link_t         left_l [DEPTH];
	key_t          right_k [DEPTH];
	logic [DEPTH-1:0] occ;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign is_ext    = (req.action == ACT_EXTRACT);
	assign empty     = (cnt_q == '0);
	assign full      = (cnt_q == CW'(DEPTH));
	assign ins_en    = accept && !is_ext && !full;
	assign ext_en    = accept && is_ext && !empty;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i] = (cnt_q > CW'(i));
		if (i == 0) begin : g_head
			assign left_l[i] = '{lt: 1'b1, key: '0};
		end else begin : g_body
			assign left_l[i] = lnk[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_k[i] = '0;
		end else begin : g_mid
			assign right_k[i] = lnk[i+1].key;
		end
		spq_cell u_cell (
			.clk       (clk),
			.ins_en    (ins_en),
			.ext_en    (ext_en),
			.new_key   (req.key),
			.occ       (occ[i]),
			.left      (left_l[i]),
			.right_key (right_k[i]),
			.link      (lnk[i])
		);
	end

	always_comb begin
		cnt_d = cnt_q;
		rsp_d = '{result_key: '0, status: ST_OK, occupancy: '0};
		if (is_ext) begin
			if (empty) begin
				rsp_d.result_key = '1;
				rsp_d.status     = ST_EMPTY;
			end else begin
				rsp_d.result_key = lnk[0].key;
				cnt_d            = cnt_q - 1'b1;
			end
		end else begin
			if (full) begin
				rsp_d.status = ST_FULL;
			end else begin
				cnt_d = cnt_q + 1'b1;
			end
		end
		rsp_d.occupancy = occ_t'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[src/spq_checker.sv]
// port-level checks for the sorted min priority queue, bound to the top level
// depends on spq_pkg and sorted_min_priority_queue_defines.svh
`include "sorted_min_priority_queue_defines.svh"

module spq_checker import spq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	`SPQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp item changed while stalled")
	`SPQ_ASSERT(a_item_out, req_valid && req_ready |=> rsp_valid, "accepted item gave no result item")
	`SPQ_ASSERT(a_empty, rsp_valid && rsp.status == ST_EMPTY |-> rsp.result_key == '1 && rsp.occupancy == '0, "empty extract with wrong key or occupancy")
	`SPQ_ASSERT(a_full, rsp_valid && rsp.status == ST_FULL |-> rsp.result_key == '0 && rsp.occupancy == occ_t'(DEPTH), "dropped insert with wrong key or occupancy")
	`SPQ_ASSERT_ALWAYS(a_reset, !arst_n |-> !rsp_valid, "result item shown during reset")

endmodule

bind sorted_min_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
